// ===== src/foreground_bounding_box_unit_assert.svh =====
// assertion macros shared by the foreground box checks
`ifndef FOREGROUND_BOUNDING_BOX_UNIT_ASSERT_SVH
`define FOREGROUND_BOUNDING_BOX_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define FGBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("foreground box check failed");

// consequence in the cycle after the condition
`define FGBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("foreground box check failed");

`endif

// ===== src/fgbb_pkg.sv =====
// shared types, constants and helpers of the foreground box unit
package fgbb_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int MAX_COLORS    = 4;
  localparam int COLOR_SLOTS   = 4;
  localparam int QUEUE_DEPTH   = 4;

  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int COUNT_W     = 3;
  localparam int IDX_W       = 2;
  localparam int THRESH_W    = 16;
  localparam int COLOR_W     = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COLOR_COUNT  = 3'd2,
    REG_THRESHOLD    = 3'd3,
    REG_BACKGROUND_0 = 3'd4,
    REG_BACKGROUND_1 = 3'd5,
    REG_BACKGROUND_2 = 3'd6,
    REG_BACKGROUND_3 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    dim_t             min_x;
    dim_t             min_y;
    pos_t             max_x;
    pos_t             max_y;
    logic             last_box;
  } box_t;

  // configuration as the datapath sees it, dimensions and count already clamped
  typedef struct packed {
    dim_t                                width;
    dim_t                                height;
    count_t                              colors;
    logic [THRESH_W-1:0]                 threshold;
    logic [COLOR_SLOTS-1:0][COLOR_W-1:0] background;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [COLOR_SLOTS-1:0] hit;
    pos_t                   x;
    pos_t                   y;
    logic                   frame_end;
    count_t                 colors;
  } item_t;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

endpackage

// ===== src/fgbb_front.sv =====
// front end: pixel position counters and per-color foreground test
module fgbb_front #(
  parameter int MAX_COLORS = fgbb_pkg::MAX_COLORS
) (
  input  logic            clk,
  input  logic            rst,
  input  fgbb_pkg::cfg_t  cfg,
  input  logic            restart,
  input  logic            take,
  input  fgbb_pkg::pixel_t pixel,
  output logic            push,
  output fgbb_pkg::item_t push_item
);
  import fgbb_pkg::*;

  pos_t col;
  pos_t row;
  logic col_end;
  logic row_end;
  logic [COLOR_SLOTS-1:0] hit;

  assign col_end = (DIM_W'(col) + DIM_W'(1)) >= cfg.width;
  assign row_end = (DIM_W'(row) + DIM_W'(1)) >= cfg.height;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (col_end && row_end) begin
        col <= '0;
        row <= '0;
      end else if (col_end) begin
        col <= '0;
        row <= row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

  // alpha * |pixel - background| against the threshold, any channel
  always_comb begin
    logic [7:0]  px   [3];
    logic [7:0]  bg   [3];
    logic [7:0]  diff [3];
    logic [15:0] prod [3];
    px[0] = pixel.pixel_red;
    px[1] = pixel.pixel_green;
    px[2] = pixel.pixel_blue;
    hit   = '0;
    for (int c = 0; c < MAX_COLORS; c++) begin
      for (int ch = 0; ch < 3; ch++) begin
        bg[ch]   = cfg.background[c][23 - 8 * ch -: 8];
        diff[ch] = (px[ch] > bg[ch]) ? (px[ch] - bg[ch]) : (bg[ch] - px[ch]);
        prod[ch] = {8'd0, pixel.pixel_alpha} * {8'd0, diff[ch]};
        if ((COUNT_W'(c) < cfg.colors) && (prod[ch] > cfg.threshold)) begin
          hit[c] = 1'b1;
        end
      end
    end
  end

  assign push                = take;
  assign push_item.hit       = hit;
  assign push_item.x         = col;
  assign push_item.y         = row;
  assign push_item.frame_end = col_end && row_end;
  assign push_item.colors    = cfg.colors;

endmodule

// ===== src/fgbb_queue.sv =====
// short first-in first-out queue between front and back
module fgbb_queue #(
  parameter int DEPTH = fgbb_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fgbb_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fgbb_pkg::item_t head
);
  import fgbb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == (PTR_W + 1)'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== src/fgbb_back.sv =====
// back end: box registers, end-of-frame snapshot and result emitter
module fgbb_back #(
  parameter int MAX_COLORS = fgbb_pkg::MAX_COLORS
) (
  input  logic            clk,
  input  logic            rst,
  input  fgbb_pkg::cfg_t  cfg,
  input  logic            reseed,
  input  logic            head_valid,
  input  fgbb_pkg::item_t head,
  output logic            pop,
  output logic            box_valid,
  output fgbb_pkg::box_t  box,
  input  logic            box_stall
);
  import fgbb_pkg::*;

  dim_t bmin_x [MAX_COLORS];
  dim_t bmin_y [MAX_COLORS];
  pos_t bmax_x [MAX_COLORS];
  pos_t bmax_y [MAX_COLORS];
  dim_t nmin_x [MAX_COLORS];
  dim_t nmin_y [MAX_COLORS];
  pos_t nmax_x [MAX_COLORS];
  pos_t nmax_y [MAX_COLORS];

  dim_t snap_min_x [COLOR_SLOTS];
  dim_t snap_min_y [COLOR_SLOTS];
  pos_t snap_max_x [COLOR_SLOTS];
  pos_t snap_max_y [COLOR_SLOTS];

  logic             emitting;
  logic [IDX_W-1:0] emit_idx;
  count_t           emit_total;
  logic             emit_last;
  logic             load;
  logic             take_end;

  // an end-of-frame item waits until the previous frame's boxes are out
  assign pop       = head_valid && (!head.frame_end || !emitting);
  assign take_end  = pop && head.frame_end;
  assign emit_last = (COUNT_W'(emit_idx) + COUNT_W'(1)) == emit_total;
  assign load      = emitting && (!box_valid || !box_stall);

  always_comb begin
    for (int c = 0; c < MAX_COLORS; c++) begin
      nmin_x[c] = bmin_x[c];
      nmin_y[c] = bmin_y[c];
      nmax_x[c] = bmax_x[c];
      nmax_y[c] = bmax_y[c];
      if (head.hit[c]) begin
        if (DIM_W'(head.x) < bmin_x[c]) nmin_x[c] = DIM_W'(head.x);
        if (DIM_W'(head.y) < bmin_y[c]) nmin_y[c] = DIM_W'(head.y);
        if (head.x > bmax_x[c]) nmax_x[c] = head.x;
        if (head.y > bmax_y[c]) nmax_y[c] = head.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_COLORS; c++) begin
        bmin_x[c] <= DIM_W'(1);
        bmin_y[c] <= DIM_W'(1);
        bmax_x[c] <= '0;
        bmax_y[c] <= '0;
      end
    end else if (reseed || take_end) begin
      for (int c = 0; c < MAX_COLORS; c++) begin
        bmin_x[c] <= cfg.width;
        bmin_y[c] <= cfg.height;
        bmax_x[c] <= '0;
        bmax_y[c] <= '0;
      end
    end else if (pop) begin
      for (int c = 0; c < MAX_COLORS; c++) begin
        bmin_x[c] <= nmin_x[c];
        bmin_y[c] <= nmin_y[c];
        bmax_x[c] <= nmax_x[c];
        bmax_y[c] <= nmax_y[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      for (int c = 0; c < MAX_COLORS; c++) begin
        snap_min_x[c] <= nmin_x[c];
        snap_min_y[c] <= nmin_y[c];
        snap_max_x[c] <= nmax_x[c];
        snap_max_y[c] <= nmax_y[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting   <= 1'b0;
      emit_idx   <= '0;
      emit_total <= COUNT_W'(1);
      box_valid  <= 1'b0;
    end else begin
      if (box_valid && !box_stall) begin
        box_valid <= 1'b0;
      end
      if (load) begin
        box_valid <= 1'b1;
        emit_idx  <= emit_idx + IDX_W'(1);
        if (emit_last) begin
          emitting <= 1'b0;
        end
      end
      if (take_end) begin
        emitting   <= 1'b1;
        emit_idx   <= '0;
        emit_total <= head.colors;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      box.color_index <= emit_idx;
      box.min_x       <= snap_min_x[emit_idx];
      box.min_y       <= snap_min_y[emit_idx];
      box.max_x       <= snap_max_x[emit_idx];
      box.max_y       <= snap_max_y[emit_idx];
      box.last_box    <= emit_last;
    end
  end

endmodule

// ===== src/foreground_bounding_box_unit.sv =====
// top level of the foreground bounding box unit
// Takes an RGBA8 frame one pixel word per clock in row-major order while the queue is not
// full and reports, for each active background color, the box around the pixels that
// differ from it. The unit sustains one pixel per clock while the queue is not full: the
// front end counts column and row and runs the foreground test for every color in the
// accept cycle, a small queue carries the classified pixel to the back end, which widens
// the boxes one pixel per cycle unless an end-of-frame pixel waits. After the last pixel
// of a frame the back end snapshots the boxes and sends one box word per active color,
// the first after that pixel has passed the queue, the emitting flag and the box
// register, the rest one per cycle while the output is not stalled. The snapshot lets
// the next frame start at once; the end-of-frame pixel of the next frame waits in the
// queue until all boxes of the previous one are out, so short frames are held back by
// the box output. Writing image_width or image_height restarts the frame. Configuration
// is always ready and must be written while the unit is idle.
module foreground_bounding_box_unit #(
  parameter int MAX_COLORS  = fgbb_pkg::MAX_COLORS,
  parameter int QUEUE_DEPTH = fgbb_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  fgbb_pkg::pixel_t                    pixel,
  // box channel
  output logic                                box_valid,
  input  logic                                box_stall,
  output fgbb_pkg::box_t                      box,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fgbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fgbb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fgbb_pkg::*;

  // raw register file
  dim_t                  image_width;
  dim_t                  image_height;
  count_t                color_count;
  logic [THRESH_W-1:0]   threshold_scaled;
  logic [COLOR_SLOTS-1:0][COLOR_W-1:0] background_color;

  cfg_t   cfg;
  count_t colors_eff;
  logic   cfg_write;
  logic   restart;
  logic   reseed;

  logic  take;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a dimension write restarts the frame: counters now, boxes next cycle with new extent
  assign restart = cfg_write &&
                   ((cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) ||
                    (cfg_reg_t'(cfg_index) == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= DIM_W'(1);
      image_height     <= DIM_W'(1);
      color_count      <= COUNT_W'(1);
      threshold_scaled <= '0;
      background_color <= {COLOR_W'(0), COLOR_W'(0), COLOR_W'(0), {COLOR_W{1'b1}}};
      reseed           <= 1'b0;
    end else begin
      reseed <= restart;
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  image_width         <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height        <= cfg_data[DIM_W-1:0];
          REG_COLOR_COUNT:  color_count         <= cfg_data[COUNT_W-1:0];
          REG_THRESHOLD:    threshold_scaled    <= cfg_data[THRESH_W-1:0];
          REG_BACKGROUND_0: background_color[0] <= cfg_data[COLOR_W-1:0];
          REG_BACKGROUND_1: background_color[1] <= cfg_data[COLOR_W-1:0];
          REG_BACKGROUND_2: background_color[2] <= cfg_data[COLOR_W-1:0];
          REG_BACKGROUND_3: background_color[3] <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // zero colors acts as one, too many acts as the supported maximum
  always_comb begin
    colors_eff = color_count;
    if (color_count == '0) begin
      colors_eff = COUNT_W'(1);
    end else if (color_count > COUNT_W'(MAX_COLORS)) begin
      colors_eff = COUNT_W'(MAX_COLORS);
    end
  end

  assign cfg.width      = clamp_dim(image_width);
  assign cfg.height     = clamp_dim(image_height);
  assign cfg.colors     = colors_eff;
  assign cfg.threshold  = threshold_scaled;
  assign cfg.background = background_color;

  // only a full queue holds the pixel stream back
  assign pixel_stall = queue_full;
  assign take        = pixel_valid && !pixel_stall;

  fgbb_front #(
    .MAX_COLORS (MAX_COLORS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .take      (take),
    .pixel     (pixel),
    .push      (push),
    .push_item (push_item)
  );

  fgbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fgbb_back #(
    .MAX_COLORS (MAX_COLORS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .reseed     (reseed),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .box_valid  (box_valid),
    .box        (box),
    .box_stall  (box_stall)
  );

endmodule

// ===== src/fgbb_checker.sv =====
// port-level checks of the foreground box unit and their bind
`include "foreground_bounding_box_unit_assert.svh"

module fgbb_checker (
  input logic             clk,
  input logic             rst,
  input logic             box_valid,
  input logic             box_stall,
  input fgbb_pkg::box_t   box
);
  import fgbb_pkg::*;

  logic [IDX_W-1:0] expect_idx;

  // boxes of one frame come out in color order starting at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_idx <= '0;
    end else if (box_valid && !box_stall) begin
      expect_idx <= box.last_box ? '0 : box.color_index + IDX_W'(1);
    end
  end

  `FGBB_ASSERT_NEXT(box_held_while_stalled, box_valid && box_stall, box_valid && $stable(box))
  `FGBB_ASSERT_NOW(box_color_order, box_valid, box.color_index == expect_idx)
  `FGBB_ASSERT_NOW(box_empty_both_axes, box_valid, (box.min_x <= DIM_W'(box.max_x)) == (box.min_y <= DIM_W'(box.max_y)))

endmodule

bind foreground_bounding_box_unit fgbb_checker u_fgbb_checker (.*);

// ===== dv/foreground_bounding_box_unit_test.sv =====
// testbench of the foreground bounding box unit: pixel frames checked against a box predictor
module foreground_bounding_box_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fgbb_pkg::*;

  // idle cycles allowed for the queue and back end to empty after the last box
  localparam int SETTLE_CYCLES = 12;
  // cycles with no word moving on any channel before the run is declared hung
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  pixel_t                 pixel       = '0;
  logic                   box_valid;
  logic                   box_stall   = 1'b0;
  box_t                   box;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int mismatch_count    = 0;
  int quiet_cycles      = 0;
  int pixels_sent       = 0;

  // register file as last written, before any clamping
  logic [DIM_W-1:0]    cfg_width;
  logic [DIM_W-1:0]    cfg_height;
  logic [COUNT_W-1:0]  cfg_colors;
  logic [THRESH_W-1:0] cfg_threshold;
  logic [COLOR_W-1:0]  cfg_background [COLOR_SLOTS];

  // frame position and the running box of each color
  int col_pos;
  int row_pos;
  int lo_x [COLOR_SLOTS];
  int lo_y [COLOR_SLOTS];
  int hi_x [COLOR_SLOTS];
  int hi_y [COLOR_SLOTS];

  // boxes predicted but not yet seen on the output, oldest first
  box_t expected_boxes [$];

  foreground_bounding_box_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box        (box),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // box predictor
  // ---------------------------------------------------------------------------

  // zero acts as one, anything past the largest frame acts as the largest
  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return int'(v);
  endfunction

  function automatic int eff_colors();
    if (cfg_colors == 0) return 1;
    if (cfg_colors > MAX_COLORS) return MAX_COLORS;
    return int'(cfg_colors);
  endfunction

  function automatic int abs_diff(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // foreground when alpha-weighted distance beats the threshold on any channel
  function automatic bit pixel_stands_out(input logic [COLOR_W-1:0] bg, input pixel_t p);
    int a;
    int lim;
    a   = int'(p.pixel_alpha);
    lim = int'(cfg_threshold);
    return (a * abs_diff(p.pixel_red,   bg[23:16]) > lim) ||
           (a * abs_diff(p.pixel_green, bg[15:8])  > lim) ||
           (a * abs_diff(p.pixel_blue,  bg[7:0])   > lim);
  endfunction

  // back to the top left corner, every box empty again (min at the far edge)
  function automatic void reseed_frame();
    col_pos = 0;
    row_pos = 0;
    for (int c = 0; c < COLOR_SLOTS; c++) begin
      lo_x[c] = eff_dim(cfg_width);
      lo_y[c] = eff_dim(cfg_height);
      hi_x[c] = 0;
      hi_y[c] = 0;
    end
  endfunction

  function automatic void reset_model();
    cfg_width         = 1;
    cfg_height        = 1;
    cfg_colors        = 1;
    cfg_threshold     = 0;
    cfg_background[0] = 24'hFFFFFF;
    cfg_background[1] = 24'h000000;
    cfg_background[2] = 24'h000000;
    cfg_background[3] = 24'h000000;
    reseed_frame();
  endfunction

  // dimension writes restart the frame, the rest only change later pixels
  function automatic void apply_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_IMAGE_WIDTH: begin
        cfg_width = v[DIM_W-1:0];
        reseed_frame();
      end
      REG_IMAGE_HEIGHT: begin
        cfg_height = v[DIM_W-1:0];
        reseed_frame();
      end
      REG_COLOR_COUNT:  cfg_colors        = v[COUNT_W-1:0];
      REG_THRESHOLD:    cfg_threshold     = v[THRESH_W-1:0];
      REG_BACKGROUND_0: cfg_background[0] = v[COLOR_W-1:0];
      REG_BACKGROUND_1: cfg_background[1] = v[COLOR_W-1:0];
      REG_BACKGROUND_2: cfg_background[2] = v[COLOR_W-1:0];
      REG_BACKGROUND_3: cfg_background[3] = v[COLOR_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted pixel: widen the boxes, and on the last pixel queue one box per color
  function automatic void predict_boxes(input pixel_t p);
    int   w;
    int   h;
    int   n;
    int   x;
    int   y;
    box_t b;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    n = eff_colors();
    x = col_pos;
    y = row_pos;
    for (int c = 0; c < n; c++) begin
      if (pixel_stands_out(cfg_background[c], p)) begin
        if (x < lo_x[c]) lo_x[c] = x;
        if (x > hi_x[c]) hi_x[c] = x;
        if (y < lo_y[c]) lo_y[c] = y;
        if (y > hi_y[c]) hi_y[c] = y;
      end
    end
    if (x + 1 >= w && y + 1 >= h) begin
      for (int c = 0; c < n; c++) begin
        b.color_index = IDX_W'(c);
        b.min_x       = DIM_W'(lo_x[c]);
        b.min_y       = DIM_W'(lo_y[c]);
        b.max_x       = POS_W'(hi_x[c]);
        b.max_y       = POS_W'(hi_y[c]);
        b.last_box    = (c == n - 1);
        expected_boxes.insert(expected_boxes.size(), b);
      end
      reseed_frame();
    end else if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  function automatic pixel_t rgba(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] a);
    return {r, g, b, a};
  endfunction

  // valid stays high after acceptance so back-to-back words need no second assignment
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    predict_boxes(p);
    pixels_sent++;
  endtask

  // stop sending, let every box drain, then give frame-interior pixels time to land
  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, v);
    @(posedge clk);
  endtask

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    box_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // box checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_boxes
    box_t want;
    if (!rst && box_valid && !box_stall) begin
      if (expected_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected box word: color %0d min (%0d,%0d) max (%0d,%0d) last %0d",
                   box.color_index, box.min_x, box.min_y, box.max_x, box.max_y,
                   box.last_box);
        end
      end else begin
        want = expected_boxes.pop_front();
        if (box.color_index !== want.color_index || box.min_x !== want.min_x ||
            box.min_y !== want.min_y || box.max_x !== want.max_x ||
            box.max_y !== want.max_y || box.last_box !== want.last_box) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("box mismatch: expected color %0d min (%0d,%0d) max (%0d,%0d) last %0d",
                     want.color_index, want.min_x, want.min_y, want.max_x, want.max_y,
                     want.last_box);
            $display("              actual   color %0d min (%0d,%0d) max (%0d,%0d) last %0d",
                     box.color_index, box.min_x, box.min_y, box.max_x, box.max_y,
                     box.last_box);
          end
        end
      end
    end
  end

  // hang detector: any word moving on any channel resets the count
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (box_valid && !box_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers give 1x1 frames against a white background, one color
  task automatic test_reset_defaults();
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));  // same as background, empty box
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));  // opaque black is foreground
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));  // zero alpha never counts
  endtask

  // full-scale difference at full alpha sits exactly on the top threshold
  task automatic test_threshold_extremes();
    drain();
    write_reg(REG_COLOR_COUNT, 4);
    write_reg(REG_BACKGROUND_0, 24'h000000);
    write_reg(REG_BACKGROUND_1, 24'hFFFFFF);
    write_reg(REG_BACKGROUND_2, 24'h808080);
    write_reg(REG_BACKGROUND_3, 24'h00FF00);
    write_reg(REG_THRESHOLD, 65025);
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    drain();
    write_reg(REG_THRESHOLD, 65024);
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    drain();
    // above the largest product nothing can be foreground
    write_reg(REG_THRESHOLD, 65535);
    send_pixel(rgba(8'hFF, 8'h00, 8'hFF, 8'hFF));
    drain();
    // zero threshold: the smallest nonzero product already counts
    write_reg(REG_THRESHOLD, 0);
    send_pixel(rgba(8'h01, 8'h00, 8'h00, 8'h01));
    send_pixel(rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
  endtask

  // out-of-range color counts clamp to one and to four
  task automatic test_color_count_clamp();
    drain();
    write_reg(REG_COLOR_COUNT, 0);
    send_pixel(rgba(8'h80, 8'h80, 8'h80, 8'hFF));
    drain();
    write_reg(REG_COLOR_COUNT, 7);
    send_pixel(rgba(8'h80, 8'h80, 8'h80, 8'hFF));
    drain();
    write_reg(REG_COLOR_COUNT, 5);
    send_pixel(rgba(8'h00, 8'hFF, 8'h00, 8'h7F));
  endtask

  // zero dimensions act as one, oversize ones as the largest frame edge
  task automatic test_dimension_clamp();
    drain();
    write_reg(REG_COLOR_COUNT, 2);
    write_reg(REG_BACKGROUND_0, 24'h000000);
    write_reg(REG_BACKGROUND_1, 24'hFFFFFF);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    drain();
    // oversize width: a few pixels of one row must not end the frame
    write_reg(REG_IMAGE_WIDTH, 8191);
    write_reg(REG_IMAGE_HEIGHT, 1);
    repeat (3) send_pixel(rgba(8'hFF, 8'h00, 8'h00, 8'hFF));
    drain();
    // oversize height with one-pixel rows, the frame is later thrown away by a width write
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 4097);
    repeat (3) send_pixel(rgba(8'h00, 8'h00, 8'hFF, 8'hFF));
  endtask

  // registers changed partway through a frame
  task automatic test_mid_frame_writes();
    drain();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_COLOR_COUNT, 2);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_BACKGROUND_0, 24'h000000);
    write_reg(REG_BACKGROUND_1, 24'hFFFFFF);
    write_reg(REG_BACKGROUND_2, 24'h000000);
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    send_pixel(rgba(8'h40, 8'h00, 8'h00, 8'hFF));
    drain();
    // more colors and a new threshold take effect from the next pixel on
    write_reg(REG_COLOR_COUNT, 4);
    write_reg(REG_THRESHOLD, 100);
    write_reg(REG_BACKGROUND_3, 24'h123456);
    repeat (4) send_pixel(rgba(8'h20, 8'hE0, 8'h10, 8'hFF));
    // a width write partway through throws the frame away
    send_pixel(rgba(8'hFF, 8'h00, 8'h00, 8'hFF));
    send_pixel(rgba(8'h00, 8'hFF, 8'h00, 8'hFF));
    drain();
    write_reg(REG_IMAGE_WIDTH, 2);
    repeat (4) send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    drain();
    // and so does a height write
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drain();
    write_reg(REG_IMAGE_HEIGHT, 1);
    repeat (2) send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
  endtask

  // half the time near one of the active backgrounds so boxes are neither always full nor empty
  function automatic pixel_t random_pixel();
    pixel_t            p;
    logic [COLOR_W-1:0] bg;
    bg = cfg_background[$urandom_range(eff_colors() - 1)];
    case ($urandom_range(3))
      0, 1: begin
        p.pixel_red   = bg[23:16] + 8'($urandom_range(2)) - 8'd1;
        p.pixel_green = bg[15:8]  + 8'($urandom_range(2)) - 8'd1;
        p.pixel_blue  = bg[7:0]   + 8'($urandom_range(2)) - 8'd1;
      end
      2: begin
        p.pixel_red   = 8'($urandom);
        p.pixel_green = 8'($urandom);
        p.pixel_blue  = 8'($urandom);
      end
      default: begin
        p.pixel_red   = $urandom_range(1) ? 8'hFF : 8'h00;
        p.pixel_green = $urandom_range(1) ? 8'hFF : 8'h00;
        p.pixel_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    endcase
    case ($urandom_range(3))
      0:       p.pixel_alpha = 8'h00;
      1:       p.pixel_alpha = 8'hFF;
      default: p.pixel_alpha = 8'($urandom);
    endcase
    return p;
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] thr;
    case ($urandom_range(4))
      0:       thr = 0;
      1:       thr = 65025;
      2:       thr = 65535;
      3:       thr = CFG_DATA_W'($urandom_range(65535));
      default: thr = CFG_DATA_W'($urandom_range(2000));
    endcase
    write_reg(REG_COLOR_COUNT, CFG_DATA_W'($urandom_range(7)));
    write_reg(REG_THRESHOLD, thr);
    if ($urandom_range(1)) write_reg(REG_BACKGROUND_0, CFG_DATA_W'($urandom));
    if ($urandom_range(1)) write_reg(REG_BACKGROUND_1, CFG_DATA_W'($urandom));
    if ($urandom_range(1)) write_reg(REG_BACKGROUND_2, CFG_DATA_W'($urandom));
    if ($urandom_range(1)) write_reg(REG_BACKGROUND_3, CFG_DATA_W'($urandom));
    // small frames keep boxes coming; zero exercises the clamp to one
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(6)));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(4)));
  endtask

  // whole frames with random content, now and then a frame cut short by a restart
  task automatic test_random_frames(input int send_pct, input int recv_pct);
    int target;
    int frame_pixels;
    int cut;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    target            = pixels_sent + 25;
    while (pixels_sent < target) begin
      drain();
      random_settings();
      frame_pixels = eff_dim(cfg_width) * eff_dim(cfg_height);
      if (frame_pixels > 1 && $urandom_range(5) == 0) begin
        cut = $urandom_range(frame_pixels - 1, 1);
        repeat (cut) send_pixel(random_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(6)));
        frame_pixels = eff_dim(cfg_width) * eff_dim(cfg_height);
      end
      repeat ($urandom_range(3, 1) * frame_pixels) send_pixel(random_pixel());
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed checks run under the first idle pattern
    sender_idle_pct   = 22;
    receiver_idle_pct = 66;
    test_reset_defaults();
    test_threshold_extremes();
    test_color_count_clamp();
    test_dimension_clamp();
    test_mid_frame_writes();

    test_random_frames(22, 66);
    test_random_frames(66, 22);
    test_random_frames(0, 0);

    drain();
    if (mismatch_count == 0 && expected_boxes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
